/* design/lz4bfd_pkg.sv */
// ---------------------------------------------------------------------------
// LZ4 block frame decoder package
// Shared types, status codes and the frame magic table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lz4bfd_pkg;

    // history window
    localparam int WINDOW_BYTES = 65536;
    localparam int WIN_AW       = $clog2(WINDOW_BYTES);

    // depth of the queue between parser and executor
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // reset value of the size limit register
    localparam logic [31:0] MAX_SIZE_RST = 32'd16777216;

    localparam int HDR_MAGIC_LEN = 8;
    localparam int HDR_LEN       = 12;

    // frame end status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC  = 3'd1;
    localparam logic [2:0] ST_SIZE_LIMIT = 3'd2;
    localparam logic [2:0] ST_TRUNCATED  = 3'd3;
    localparam logic [2:0] ST_LIT_OVER   = 3'd4;
    localparam logic [2:0] ST_BAD_MATCH  = 3'd5;
    localparam logic [2:0] ST_SIZE_MISM  = 3'd6;
    localparam logic [2:0] ST_BYTE_COPY  = 3'd7;

    // input beat kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // result kinds
    localparam logic RES_DATA   = 1'b0;
    localparam logic RES_STATUS = 1'b1;

    // parser phase, one-hot
    typedef enum logic [7:0] {
        PH_HEADER    = 8'b0000_0001,
        PH_TOKEN     = 8'b0000_0010,
        PH_LIT_EXT   = 8'b0000_0100,
        PH_LITERALS  = 8'b0000_1000,
        PH_OFF_LO    = 8'b0001_0000,
        PH_OFF_HI    = 8'b0010_0000,
        PH_MATCH_EXT = 8'b0100_0000,
        PH_COPY      = 8'b1000_0000
    } t_phase;

    // one operation for the executor: optional data byte then optional status
    typedef struct packed {
        logic              has_data;
        logic              is_copy;
        logic [7:0]        byte_val;
        logic [WIN_AW-1:0] src;
        logic [WIN_AW-1:0] dst;
        logic              busy;
        logic              has_stat;
        logic [2:0]        stat;
    } t_op;

    localparam int OP_W = $bits(t_op);

    // frame magic
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0: v = 8'h6D;
            3'd1: v = 8'h6F;
            3'd2: v = 8'h7A;
            3'd3: v = 8'h4C;
            3'd4: v = 8'h7A;
            3'd5: v = 8'h34;
            3'd6: v = 8'h30;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // saturating 32-bit add of a byte
    function automatic logic [31:0] sat_add8(input logic [31:0] a, input logic [7:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {25'd0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

`default_nettype wire

/* design/lz4bfd_front.sv */
// ---------------------------------------------------------------------------
// LZ4 block frame decoder: parser
// Takes input beats, walks header and sequences, keeps counters and
// issues at most one operation per beat towards the executor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lz4bfd_front import lz4bfd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_accept,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    output t_op              o_op,
    output logic             o_push
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_hc, n_hc;
    logic [31:0] r_decl, n_decl;
    logic [31:0] r_prod, n_prod;
    logic [31:0] r_ll, n_ll;
    logic [31:0] r_ml, n_ml;
    logic [15:0] r_dist, n_dist;
    logic [3:0]  r_mn, n_mn;
    logic        r_drop, n_drop;
    logic        r_endp, n_endp;
    logic [31:0] r_max;

    logic        do_end, end_last, end_fs, do_restart, sl_go, sm_go;
    logic [2:0]  end_st;
    logic [4:0]  hc_inc;

    // size limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_SIZE_RST;
        end else if (i_cfg_we) begin
            r_max <= i_cfg_wdata;
        end
    end

    // next state and operation
    always_comb begin
        n_phase = r_phase; n_hc = r_hc; n_decl = r_decl; n_prod = r_prod;
        n_ll = r_ll; n_ml = r_ml; n_dist = r_dist; n_mn = r_mn;
        n_drop = r_drop; n_endp = r_endp;
        do_end = 1'b0; end_last = 1'b0; end_fs = 1'b0; end_st = ST_OK;
        do_restart = 1'b0; sl_go = 1'b0; sm_go = 1'b0;
        hc_inc = {1'b0, r_hc} + 5'd1;
        o_op.has_data = 1'b0;
        o_op.is_copy  = 1'b0;
        o_op.byte_val = i_in_byte;
        o_op.src      = WIN_AW'(r_prod - {16'd0, r_dist});
        o_op.dst      = r_prod[WIN_AW-1:0];
        o_op.busy     = 1'b0;
        o_op.has_stat = 1'b0;
        o_op.stat     = ST_OK;

        if (i_accept) begin
            if (i_kind == KIND_TICK) begin
                // copy tick
                if (!r_drop && r_phase == PH_COPY && r_ml != 32'd0) begin
                    o_op.has_data = 1'b1;
                    o_op.is_copy  = 1'b1;
                    o_op.busy     = (r_ml != 32'd1);
                    n_prod = r_prod + 32'd1;
                    n_ml   = r_ml - 32'd1;
                    if (r_ml == 32'd1) begin
                        if (r_endp) begin
                            do_end = 1'b1; end_last = 1'b1; end_fs = 1'b1;
                        end else begin
                            n_phase = PH_TOKEN;
                        end
                    end
                end
            end else if (r_drop) begin
                do_restart = i_in_last;
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        if (r_hc < 4'(HDR_MAGIC_LEN) && i_in_byte != magic_byte(r_hc[2:0])) begin
                            do_end = 1'b1; end_st = ST_BAD_MAGIC; end_last = i_in_last;
                        end else begin
                            if (r_hc >= 4'(HDR_MAGIC_LEN)) begin
                                n_decl = r_decl | ({24'd0, i_in_byte} << {r_hc[1:0], 3'b000});
                            end
                            n_hc = hc_inc[3:0];
                            if (hc_inc < 5'(HDR_LEN)) begin
                                if (i_in_last) begin
                                    do_end = 1'b1; end_st = ST_BAD_MAGIC; end_last = 1'b1;
                                end
                            end else if (n_decl > r_max) begin
                                do_end = 1'b1; end_st = ST_SIZE_LIMIT; end_last = i_in_last;
                            end else begin
                                n_phase = PH_TOKEN;
                                if (i_in_last) begin
                                    do_end = 1'b1; end_last = 1'b1; end_fs = 1'b1;
                                end
                            end
                        end
                    end
                    PH_TOKEN: begin
                        n_mn = i_in_byte[3:0];
                        n_ll = {28'd0, i_in_byte[7:4]};
                        if (i_in_byte[7:4] == 4'hF) begin
                            n_phase = PH_LIT_EXT;
                            if (i_in_last) begin
                                do_end = 1'b1; end_st = ST_TRUNCATED; end_last = 1'b1;
                            end
                        end else begin
                            sl_go = 1'b1;
                        end
                    end
                    PH_LIT_EXT: begin
                        n_ll = sat_add8(r_ll, i_in_byte);
                        if (i_in_byte == 8'hFF) begin
                            if (i_in_last) begin
                                do_end = 1'b1; end_st = ST_TRUNCATED; end_last = 1'b1;
                            end
                        end else begin
                            sl_go = 1'b1;
                        end
                    end
                    PH_LITERALS: begin
                        o_op.has_data = 1'b1;
                        n_prod = r_prod + 32'd1;
                        n_ll   = r_ll - 32'd1;
                        if (r_ll == 32'd1) begin
                            if (i_in_last) begin
                                do_end = 1'b1; end_last = 1'b1; end_fs = 1'b1;
                            end else begin
                                n_phase = PH_OFF_LO;
                            end
                        end else if (i_in_last) begin
                            do_end = 1'b1; end_st = ST_TRUNCATED; end_last = 1'b1;
                        end
                    end
                    PH_OFF_LO: begin
                        n_dist  = {8'd0, i_in_byte};
                        n_phase = PH_OFF_HI;
                        if (i_in_last) begin
                            do_end = 1'b1; end_st = ST_TRUNCATED; end_last = 1'b1;
                        end
                    end
                    PH_OFF_HI: begin
                        n_dist = {i_in_byte, r_dist[7:0]};
                        n_ml   = {28'd0, r_mn} + 32'd4;
                        if (r_mn == 4'hF) begin
                            n_phase = PH_MATCH_EXT;
                            if (i_in_last) begin
                                do_end = 1'b1; end_st = ST_TRUNCATED; end_last = 1'b1;
                            end
                        end else begin
                            sm_go = 1'b1;
                        end
                    end
                    PH_MATCH_EXT: begin
                        n_ml = sat_add8(r_ml, i_in_byte);
                        if (i_in_byte == 8'hFF) begin
                            if (i_in_last) begin
                                do_end = 1'b1; end_st = ST_TRUNCATED; end_last = 1'b1;
                            end
                        end else begin
                            sm_go = 1'b1;
                        end
                    end
                    default: begin
                        do_end = 1'b1; end_st = ST_BYTE_COPY; end_last = i_in_last;
                    end
                endcase

                // literal length complete
                if (sl_go) begin
                    if (({1'b0, r_prod} + {1'b0, n_ll}) > {1'b0, r_decl}) begin
                        do_end = 1'b1; end_st = ST_LIT_OVER; end_last = i_in_last;
                    end else if (n_ll == 32'd0) begin
                        if (i_in_last) begin
                            do_end = 1'b1; end_last = 1'b1; end_fs = 1'b1;
                        end else begin
                            n_phase = PH_OFF_LO;
                        end
                    end else begin
                        n_phase = PH_LITERALS;
                        if (i_in_last) begin
                            do_end = 1'b1; end_st = ST_TRUNCATED; end_last = 1'b1;
                        end
                    end
                end

                // match length complete
                if (sm_go) begin
                    if (n_dist == 16'd0 || {16'd0, n_dist} > r_prod ||
                        ({1'b0, r_prod} + {1'b0, n_ml}) > {1'b0, r_decl}) begin
                        do_end = 1'b1; end_st = ST_BAD_MATCH; end_last = i_in_last;
                    end else begin
                        n_phase = PH_COPY;
                        n_endp  = i_in_last;
                    end
                end
            end
        end

        // frame end
        if (do_end) begin
            o_op.has_stat = 1'b1;
            o_op.stat     = end_fs ? ((n_prod == n_decl) ? ST_OK : ST_SIZE_MISM) : end_st;
        end
        if ((do_end && end_last) || do_restart) begin
            n_phase = PH_HEADER; n_hc = 4'd0; n_decl = 32'd0; n_prod = 32'd0;
            n_ll = 32'd0; n_ml = 32'd0; n_dist = 16'd0; n_mn = 4'd0;
            n_drop = 1'b0; n_endp = 1'b0;
        end else if (do_end) begin
            n_drop = 1'b1;
        end
        o_push = o_op.has_data || o_op.has_stat;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_hc <= 4'd0; r_decl <= 32'd0; r_prod <= 32'd0;
            r_ll <= 32'd0; r_ml <= 32'd0; r_dist <= 16'd0; r_mn <= 4'd0;
            r_drop <= 1'b0; r_endp <= 1'b0;
        end else begin
            r_phase <= n_phase; r_hc <= n_hc; r_decl <= n_decl; r_prod <= n_prod;
            r_ll <= n_ll; r_ml <= n_ml; r_dist <= n_dist; r_mn <= n_mn;
            r_drop <= n_drop; r_endp <= n_endp;
        end
    end

endmodule

`default_nettype wire

/* design/lz4bfd_fifo.sv */
// ---------------------------------------------------------------------------
// LZ4 block frame decoder: operation queue
// Small FIFO between parser and executor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lz4bfd_fifo import lz4bfd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_op       i_op,
    input  wire logic i_pop,
    output t_op       o_op,
    output logic      o_valid,
    output logic      o_full
);

    t_op          r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    assign o_op    = r_mem[r_rp];
    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

endmodule

`default_nettype wire

/* design/lz4bfd_back.sv */
// ---------------------------------------------------------------------------
// LZ4 block frame decoder: executor
// Reads and writes the history ring and drives data and status beats.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lz4bfd_back import lz4bfd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  t_op             i_op,
    input  wire logic       i_op_valid,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_result_kind,
    output logic [7:0]      o_out_byte,
    output logic [2:0]      o_status,
    output logic            o_copy_busy,
    output logic            o_frame_end
);

    logic [7:0] r_ring [WINDOW_BYTES];

    // stage B: operation with read data
    logic       r_b_valid;
    t_op        r_b_op;
    logic [7:0] r_rd;
    logic       r_fwd;
    logic [7:0] r_fwd_byte;

    // stage C: output register
    logic       r_c_data, r_c_stat;
    logic [7:0] r_c_byte;
    logic       r_c_busy;
    logic [2:0] r_c_st;

    logic       c_free, b_adv, out_take, hit;
    logic [7:0] b_val;

    assign b_val    = r_b_op.is_copy ? (r_fwd ? r_fwd_byte : r_rd) : r_b_op.byte_val;
    assign out_take = o_valid && !i_stall;
    assign c_free   = !(r_c_data || r_c_stat) || (out_take && !(r_c_data && r_c_stat));
    assign b_adv    = r_b_valid && c_free;
    assign o_pop    = i_op_valid && (!r_b_valid || b_adv);
    assign hit      = b_adv && r_b_op.has_data && (r_b_op.dst == i_op.src);

    // history ring
    always_ff @(posedge i_clk) begin
        if (b_adv && r_b_op.has_data) begin
            r_ring[r_b_op.dst] <= b_val;
        end
        if (o_pop) begin
            r_rd <= r_ring[i_op.src];
        end
    end

    // stage B payload, with bypass of the write in flight
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_op     <= i_op;
            r_fwd      <= hit;
            r_fwd_byte <= b_val;
        end
    end

    // stage C payload
    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_c_byte <= b_val;
            r_c_busy <= r_b_op.busy;
            r_c_st   <= r_b_op.stat;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_data  <= 1'b0;
            r_c_stat  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (b_adv) begin
                r_c_data <= r_b_op.has_data;
                r_c_stat <= r_b_op.has_stat;
            end else if (out_take) begin
                if (r_c_data) r_c_data <= 1'b0;
                else          r_c_stat <= 1'b0;
            end
        end
    end

    // result beat: data first, then status
    always_comb begin
        o_valid = r_c_data || r_c_stat;
        if (r_c_data) begin
            o_result_kind = RES_DATA;
            o_out_byte    = r_c_byte;
            o_status      = ST_OK;
            o_copy_busy   = r_c_busy;
            o_frame_end   = 1'b0;
        end else begin
            o_result_kind = RES_STATUS;
            o_out_byte    = 8'd0;
            o_status      = r_c_st;
            o_copy_busy   = 1'b0;
            o_frame_end   = 1'b1;
        end
    end

endmodule

`default_nettype wire

/* design/lz4_block_frame_decoder_unit.sv */
// A beat's results are registered through the operation queue, stage B and stage C; stalls delay them.
// Throughput: one input beat per cycle while o_stall is low; a beat that ends a frame after a literal
// or the last copy yields two output beats (data then status).
// The history ring is one memory with one write and one read port per cycle.
// Reset: synchronous, active low; clears parser state, queue and output stages;
// the history ring is not cleared and the size limit returns to 16777216.
// ---------------------------------------------------------------------------
// LZ4 block frame decoder top level
// Parser, operation queue and executor joined with valid/stall channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lz4_block_frame_decoder_unit import lz4bfd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_result_kind,
    output logic [7:0]       o_out_byte,
    output logic [2:0]       o_status,
    output logic             o_copy_busy,
    output logic             o_frame_end
);

    t_op  f_op, q_op;
    logic f_push, q_valid, q_full, q_pop;

    assign o_stall = q_full;

    lz4bfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (i_valid && !q_full),
        .i_kind      (i_kind),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_op        (f_op),
        .o_push      (f_push)
    );

    lz4bfd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_op    (f_op),
        .i_pop   (q_pop),
        .o_op    (q_op),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    lz4bfd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (q_op),
        .i_op_valid    (q_valid),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result_kind (o_result_kind),
        .o_out_byte    (o_out_byte),
        .o_status      (o_status),
        .o_copy_busy   (o_copy_busy),
        .o_frame_end   (o_frame_end)
    );

endmodule

`default_nettype wire
